/* rtl/tlshp_pkg.sv */
// Shared types, codes and helpers for the TLS hello parser.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tlshp_pkg;

  // Capacity of suite items per payload
  localparam int MaxSuitesDefault = 64;

  // Parse phases
  localparam logic [3:0] PhRec      = 4'd0;
  localparam logic [3:0] PhHs       = 4'd1;
  localparam logic [3:0] PhRand     = 4'd2;
  localparam logic [3:0] PhSidLen   = 4'd3;
  localparam logic [3:0] PhSid      = 4'd4;
  localparam logic [3:0] PhCsLenHi  = 4'd5;
  localparam logic [3:0] PhCsLenLo  = 4'd6;
  localparam logic [3:0] PhCsHi     = 4'd7;
  localparam logic [3:0] PhCsLo     = 4'd8;
  localparam logic [3:0] PhCompLen  = 4'd9;
  localparam logic [3:0] PhComp     = 4'd10;
  localparam logic [3:0] PhExtHi    = 4'd11;
  localparam logic [3:0] PhExtLo    = 4'd12;
  localparam logic [3:0] PhExtBody  = 4'd13;
  localparam logic [3:0] PhDone     = 4'd14;
  localparam logic [3:0] PhError    = 4'd15;

  // Status codes
  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StTruncated = 3'd1;
  localparam logic [2:0] StBadRecord = 3'd2;
  localparam logic [2:0] StBadType   = 3'd3;
  localparam logic [2:0] StBadVer    = 3'd4;
  localparam logic [2:0] StLongSid   = 3'd5;
  localparam logic [2:0] StOffsetOvf = 3'd6;

  // Result kinds
  localparam logic KindSuite  = 1'b0;
  localparam logic KindStatus = 1'b1;

  // Protocol constants
  localparam logic [7:0]  RecTypeHandshake = 8'd22;
  localparam logic [7:0]  VerMajor         = 8'd3;
  localparam logic [7:0]  VerMinorMax      = 8'd3;
  localparam logic [7:0]  HsClientHello    = 8'd1;
  localparam logic [7:0]  HsServerHello    = 8'd2;
  localparam logic [7:0]  SessionIdMax     = 8'd32;
  localparam logic [15:0] HsHeaderLen      = 16'd6;
  localparam logic [15:0] RandomLen        = 16'd32;
  localparam logic [15:0] GreaseMask       = 16'h0F0F;
  localparam logic [15:0] GreasePattern    = 16'h0A0A;
  localparam logic [15:0] PosMax           = 16'hFFFF;

  // Result queue depth
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // One result item
  typedef struct packed {
    logic        kind;
    logic [15:0] suite;
    logic [2:0]  status;
    logic        srv_hello;
    logic [15:0] ext_offset;
    logic [15:0] ext_length;
    logic        last_result;
  } result_t;

  // Results produced by one accepted beat
  typedef struct packed {
    logic [1:0] count;
    result_t    res_a;
    result_t    res_b;
  } push_t;

  function automatic logic is_grease(input logic [15:0] v);
    is_grease = ((v & GreaseMask) == GreasePattern) && (v[15:8] == v[7:0]);
  endfunction

endpackage

`default_nettype wire

/* rtl/tlshp_parse.sv */
// Parse state and per-beat decode of the hello payload.
// Depends on tlshp_pkg; feeds tlshp_outq with zero to two results per beat.
`default_nettype none

module tlshp_parse #(
  parameter int MAX_SUITES = tlshp_pkg::MaxSuitesDefault
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fire,
  input  wire logic [7:0]      data_byte,
  input  wire logic            first,
  input  wire logic            last,
  input  wire logic            from_quic,
  output tlshp_pkg::push_t     push
);

  localparam logic [7:0] MaxSuitesC = 8'(MAX_SUITES);

  logic [15:0] pos_r, rem_r, ext_start_r, ext_size_r;
  logic [3:0]  phase_r;
  logic [7:0]  len_hi_r, suite_hi_r, emitted_r;
  logic        srv_r;
  logic [2:0]  err_r;

  logic [15:0] pos_nxt, rem_nxt, ext_start_nxt, ext_size_nxt;
  logic [3:0]  phase_nxt;
  logic [7:0]  len_hi_nxt, suite_hi_nxt, emitted_nxt;
  logic        srv_nxt;
  logic [2:0]  err_nxt;

  // State as seen by this beat, after a possible restart
  logic [15:0] cur_pos, cur_rem, cur_ext_start, cur_ext_size;
  logic [3:0]  cur_phase;
  logic [7:0]  cur_len_hi, cur_suite_hi, cur_emitted;
  logic        cur_srv;
  logic [2:0]  cur_err;

  logic [2:0]  hs_idx;
  logic [15:0] suite_val;
  logic        emit;
  tlshp_pkg::result_t suite_res, stat_res;

  // Restart on the first beat of a payload
  always_comb begin
    if (first) begin
      cur_pos       = '0;
      cur_rem       = from_quic ? tlshp_pkg::HsHeaderLen : '0;
      cur_phase     = from_quic ? tlshp_pkg::PhHs : tlshp_pkg::PhRec;
      cur_len_hi    = '0;
      cur_suite_hi  = '0;
      cur_emitted   = '0;
      cur_srv       = 1'b0;
      cur_err       = tlshp_pkg::StOk;
      cur_ext_start = '0;
      cur_ext_size  = '0;
    end else begin
      cur_pos       = pos_r;
      cur_rem       = rem_r;
      cur_phase     = phase_r;
      cur_len_hi    = len_hi_r;
      cur_suite_hi  = suite_hi_r;
      cur_emitted   = emitted_r;
      cur_srv       = srv_r;
      cur_err       = err_r;
      cur_ext_start = ext_start_r;
      cur_ext_size  = ext_size_r;
    end
  end

  assign hs_idx    = 3'd6 - cur_rem[2:0];
  assign suite_val = {cur_suite_hi, data_byte};

  // Advance the phase machine by one byte
  always_comb begin
    rem_nxt       = cur_rem;
    phase_nxt     = cur_phase;
    len_hi_nxt    = cur_len_hi;
    suite_hi_nxt  = cur_suite_hi;
    emitted_nxt   = cur_emitted;
    srv_nxt       = cur_srv;
    err_nxt       = cur_err;
    ext_start_nxt = cur_ext_start;
    ext_size_nxt  = cur_ext_size;
    emit          = 1'b0;
    case (cur_phase)
      tlshp_pkg::PhRec: begin
        if (cur_pos == 16'd0 && data_byte != tlshp_pkg::RecTypeHandshake) begin
          err_nxt = tlshp_pkg::StBadRecord; phase_nxt = tlshp_pkg::PhError;
        end else if (cur_pos == 16'd1 && data_byte != tlshp_pkg::VerMajor) begin
          err_nxt = tlshp_pkg::StBadRecord; phase_nxt = tlshp_pkg::PhError;
        end else if (cur_pos == 16'd2 && data_byte > tlshp_pkg::VerMinorMax) begin
          err_nxt = tlshp_pkg::StBadRecord; phase_nxt = tlshp_pkg::PhError;
        end else if (cur_pos >= 16'd4) begin
          phase_nxt = tlshp_pkg::PhHs; rem_nxt = tlshp_pkg::HsHeaderLen;
        end
      end
      tlshp_pkg::PhHs: begin
        if (hs_idx == 3'd0 && data_byte != tlshp_pkg::HsClientHello &&
            data_byte != tlshp_pkg::HsServerHello) begin
          err_nxt = tlshp_pkg::StBadType; phase_nxt = tlshp_pkg::PhError;
        end else if (hs_idx == 3'd4 && data_byte != tlshp_pkg::VerMajor) begin
          err_nxt = tlshp_pkg::StBadVer; phase_nxt = tlshp_pkg::PhError;
        end else if (hs_idx == 3'd5 &&
                     (data_byte == 8'd0 || data_byte > tlshp_pkg::VerMinorMax)) begin
          err_nxt = tlshp_pkg::StBadVer; phase_nxt = tlshp_pkg::PhError;
        end else begin
          if (hs_idx == 3'd0) srv_nxt = (data_byte == tlshp_pkg::HsServerHello);
          if (cur_rem <= 16'd1) begin
            phase_nxt = tlshp_pkg::PhRand; rem_nxt = tlshp_pkg::RandomLen;
          end else begin
            rem_nxt = cur_rem - 16'd1;
          end
        end
      end
      tlshp_pkg::PhRand: begin
        if (cur_rem <= 16'd1) begin
          rem_nxt = '0; phase_nxt = tlshp_pkg::PhSidLen;
        end else begin
          rem_nxt = cur_rem - 16'd1;
        end
      end
      tlshp_pkg::PhSidLen: begin
        if (data_byte > tlshp_pkg::SessionIdMax) begin
          err_nxt = tlshp_pkg::StLongSid; phase_nxt = tlshp_pkg::PhError;
        end else begin
          rem_nxt   = {8'd0, data_byte};
          phase_nxt = (data_byte != 8'd0) ? tlshp_pkg::PhSid : tlshp_pkg::PhCsLenHi;
        end
      end
      tlshp_pkg::PhSid: begin
        if (cur_rem <= 16'd1) begin
          rem_nxt = '0; phase_nxt = tlshp_pkg::PhCsLenHi;
        end else begin
          rem_nxt = cur_rem - 16'd1;
        end
      end
      tlshp_pkg::PhCsLenHi: begin
        len_hi_nxt = data_byte;
        phase_nxt  = tlshp_pkg::PhCsLenLo;
      end
      tlshp_pkg::PhCsLenLo: begin
        if (cur_srv) begin
          phase_nxt = tlshp_pkg::PhCompLen;
        end else begin
          rem_nxt   = {cur_len_hi, data_byte};
          phase_nxt = ({cur_len_hi, data_byte} != 16'd0) ? tlshp_pkg::PhCsHi
                                                         : tlshp_pkg::PhCompLen;
        end
      end
      tlshp_pkg::PhCsHi: begin
        if (cur_rem <= 16'd1) begin
          rem_nxt = '0; phase_nxt = tlshp_pkg::PhCompLen;
        end else begin
          suite_hi_nxt = data_byte;
          rem_nxt      = cur_rem - 16'd1;
          phase_nxt    = tlshp_pkg::PhCsLo;
        end
      end
      tlshp_pkg::PhCsLo: begin
        if (cur_rem != 16'd0) rem_nxt = cur_rem - 16'd1;
        emit = !tlshp_pkg::is_grease(suite_val) && (cur_emitted < MaxSuitesC);
        if (emit) emitted_nxt = cur_emitted + 8'd1;
        phase_nxt = (rem_nxt != 16'd0) ? tlshp_pkg::PhCsHi : tlshp_pkg::PhCompLen;
      end
      tlshp_pkg::PhCompLen: begin
        if (cur_srv) begin
          phase_nxt = tlshp_pkg::PhExtHi;
        end else begin
          rem_nxt   = {8'd0, data_byte};
          phase_nxt = (data_byte != 8'd0) ? tlshp_pkg::PhComp : tlshp_pkg::PhExtHi;
        end
      end
      tlshp_pkg::PhComp: begin
        if (cur_rem <= 16'd1) begin
          rem_nxt = '0; phase_nxt = tlshp_pkg::PhExtHi;
        end else begin
          rem_nxt = cur_rem - 16'd1;
        end
      end
      tlshp_pkg::PhExtHi: begin
        len_hi_nxt = data_byte;
        phase_nxt  = tlshp_pkg::PhExtLo;
      end
      tlshp_pkg::PhExtLo: begin
        if (cur_pos == tlshp_pkg::PosMax) begin
          err_nxt = tlshp_pkg::StOffsetOvf; phase_nxt = tlshp_pkg::PhError;
        end else begin
          ext_start_nxt = cur_pos + 16'd1;
          ext_size_nxt  = {cur_len_hi, data_byte};
          rem_nxt       = {cur_len_hi, data_byte};
          phase_nxt     = ({cur_len_hi, data_byte} != 16'd0) ? tlshp_pkg::PhExtBody
                                                             : tlshp_pkg::PhDone;
        end
      end
      tlshp_pkg::PhExtBody: begin
        if (cur_rem <= 16'd1) begin
          rem_nxt = '0; phase_nxt = tlshp_pkg::PhDone;
        end else begin
          rem_nxt = cur_rem - 16'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // Saturate the byte position
  assign pos_nxt = (cur_pos != tlshp_pkg::PosMax) ? cur_pos + 16'd1 : cur_pos;

  // Build the suite and status items
  always_comb begin
    suite_res             = '0;
    suite_res.kind        = tlshp_pkg::KindSuite;
    suite_res.suite       = suite_val;
    suite_res.last_result = !last;
    stat_res              = '0;
    stat_res.kind         = tlshp_pkg::KindStatus;
    stat_res.last_result  = 1'b1;
    if (phase_nxt == tlshp_pkg::PhDone) begin
      stat_res.status     = tlshp_pkg::StOk;
      stat_res.srv_hello  = srv_nxt;
      stat_res.ext_offset = ext_start_nxt;
      stat_res.ext_length = ext_size_nxt;
    end else if (phase_nxt == tlshp_pkg::PhError) begin
      stat_res.status = err_nxt;
    end else begin
      stat_res.status = tlshp_pkg::StTruncated;
    end
  end

  // Order results: suite item first, status item after it
  always_comb begin
    push.count = {1'b0, fire & emit} + {1'b0, fire & last};
    push.res_a = emit ? suite_res : stat_res;
    push.res_b = stat_res;
  end

  // Hold the parse state; update on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      rem_r       <= '0;
      phase_r     <= tlshp_pkg::PhRec;
      len_hi_r    <= '0;
      suite_hi_r  <= '0;
      emitted_r   <= '0;
      srv_r       <= 1'b0;
      err_r       <= tlshp_pkg::StOk;
      ext_start_r <= '0;
      ext_size_r  <= '0;
    end else if (fire) begin
      pos_r       <= pos_nxt;
      rem_r       <= rem_nxt;
      phase_r     <= phase_nxt;
      len_hi_r    <= len_hi_nxt;
      suite_hi_r  <= suite_hi_nxt;
      emitted_r   <= emitted_nxt;
      srv_r       <= srv_nxt;
      err_r       <= err_nxt;
      ext_start_r <= ext_start_nxt;
      ext_size_r  <= ext_size_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/tlshp_outq.sv */
// Result queue: takes up to two results per cycle, hands out one per beat.
// Depends on tlshp_pkg; sits between tlshp_parse and the output channel.
`default_nettype none

module tlshp_outq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  tlshp_pkg::push_t        push,
  output logic                    room,
  output logic                    q_valid,
  input  wire logic               q_ready,
  output tlshp_pkg::result_t      q_data
);

  localparam int DepthM2 = tlshp_pkg::QDepth - 2;

  tlshp_pkg::result_t mem [tlshp_pkg::QDepth];

  logic [tlshp_pkg::QPtrW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [tlshp_pkg::QCntW-1:0] cnt_r, cnt_nxt;
  logic [tlshp_pkg::QPtrW-1:0] wr_ptr_b;
  logic                        pop;

  assign pop      = q_valid & q_ready;
  assign wr_ptr_b = wr_ptr_r + tlshp_pkg::QPtrW'(1);

  assign q_valid = (cnt_r != '0);
  assign q_data  = mem[rd_ptr_r];
  // Leave space for a two-result beat
  assign room    = (cnt_r <= tlshp_pkg::QCntW'(DepthM2));

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + tlshp_pkg::QPtrW'(push.count);
    rd_ptr_nxt = rd_ptr_r + tlshp_pkg::QPtrW'(pop);
    cnt_nxt    = cnt_r + tlshp_pkg::QCntW'(push.count) - tlshp_pkg::QCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store results
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr_r] <= push.res_a;
    if (push.count == 2'd2) mem[wr_ptr_b] <= push.res_b;
  end

endmodule

`default_nettype wire

/* rtl/tls_hello_parser_unit.sv */
// TLS hello parser top level: stream ports, parse stage and result queue.
// Depends on tlshp_pkg, tlshp_parse and tlshp_outq.
//
// Usage: feed a TLS Client or Server Hello payload one byte per beat on the
// in_ channel. in_tuser[0] marks the first byte and restarts parsing;
// in_tuser[1] says the payload has no record header (QUIC), sampled with the
// first byte; in_tlast marks the final byte.
// Results leave on the out_ channel. out_tuser is 0 for a cipher suite item
// and 1 for the status item sent after the final byte; out_tlast marks the
// last result caused by one input byte.
// Results are registered in the result queue, which drives out_.
// Throughput: one byte per cycle while in_tready is high. A final byte
// that also closes a cipher suite makes two results, which drain one per
// cycle from a four-entry result queue; in_tready is low while the queue
// holds more than two. Reset clears the parse state to "record header
// expected" and empties the queue. When the receiver stalls, the queue fills
// and in_tready drops; no result is lost.
`default_nettype none

module tls_hello_parser_unit #(
  parameter int MAX_SUITES = tlshp_pkg::MaxSuitesDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic [1:0]  in_tuser,   // [0] first, [1] from_quic
  input  wire logic        in_tlast,   // last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [15:0] suite, [18:16] status,
                                       // [19] srv_hello, [35:20] ext_offset,
                                       // [51:36] ext_length, [55:52] zero
  output logic             out_tuser,  // kind
  output logic             out_tlast   // last_result
);

  tlshp_pkg::push_t   push;
  tlshp_pkg::result_t q_data;
  logic               fire;
  logic               room;

  assign in_tready = room;
  assign fire      = in_tvalid & room;

  tlshp_parse #(
    .MAX_SUITES (MAX_SUITES)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .data_byte (in_tdata),
    .first     (in_tuser[0]),
    .last      (in_tlast),
    .from_quic (in_tuser[1]),
    .push      (push)
  );

  tlshp_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .room    (room),
    .q_valid (out_tvalid),
    .q_ready (out_tready),
    .q_data  (q_data)
  );

  // Pack the result beat
  assign out_tdata = {4'd0, q_data.ext_length, q_data.ext_offset,
                      q_data.srv_hello, q_data.status, q_data.suite};
  assign out_tuser = q_data.kind;
  assign out_tlast = q_data.last_result;

endmodule

`default_nettype wire

/* rtl/tlshp_check.sv */
// Port-level checks for the TLS hello parser, bound to the top level.
// Depends on tlshp_pkg and tls_hello_parser_unit.
`default_nettype none

module tlshp_check (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        out_tlast
);

  // A status item always closes the results of its byte
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == tlshp_pkg::KindStatus |-> out_tlast)
    else $error("status beat without tlast");

  // A suite item carries nothing but the suite code
  a_suite_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == tlshp_pkg::KindSuite |-> out_tdata[55:16] == '0)
    else $error("suite beat with nonzero status fields");

  // A failed status reports no hello type and no extensions section
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == tlshp_pkg::KindStatus &&
    out_tdata[18:16] != tlshp_pkg::StOk |-> out_tdata[55:19] == '0 &&
    out_tdata[15:0] == '0)
    else $error("failed status beat with payload fields");

  // A stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("output beat changed while stalled");

endmodule

bind tls_hello_parser_unit tlshp_check u_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

/* tb/sv/tls_hello_parser_checker.sv */
// Result checker for the TLS hello parser: watches both stream channels,
// predicts the cipher suite and status beats from each accepted payload byte
// and compares them in order. Depends on tlshp_pkg.
`timescale 1ns / 1ps

module tls_hello_parser_checker #(
  parameter int MAX_SUITES = tlshp_pkg::MaxSuitesDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [0] first, [1] from_quic
  input  logic        in_tlast,   // last
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,  // [15:0] suite, [18:16] status,
                                  // [19] srv_hello, [35:20] ext_offset,
                                  // [51:36] ext_length, [55:52] zero
  input  logic        out_tuser,  // kind
  input  logic        out_tlast,  // last_result
  output int          mismatches,
  output int          results_due
);

  // Parser state mirrored from the byte stream
  logic [15:0] byte_pos;
  logic [3:0]  parse_phase;
  logic [15:0] bytes_left;
  logic [7:0]  len_msb;
  logic [7:0]  suite_msb;
  logic [7:0]  suites_sent;
  logic        is_server;
  logic [2:0]  latched_status;
  logic [15:0] ext_start;
  logic [15:0] ext_size;

  // Suite and status beats predicted but not yet seen
  tlshp_pkg::result_t hello_results_due[$];
  tlshp_pkg::result_t due_beat;
  tlshp_pkg::result_t seen_beat;

  // GREASE values: both bytes equal, each with low nibble 0xA
  function automatic logic reserved_suite_code(input logic [15:0] code);
    return (code[15:8] == code[7:0]) && (code[3:0] == 4'hA);
  endfunction

  task automatic restart_parse(input logic quic);
    byte_pos       = '0;
    bytes_left     = '0;
    len_msb        = '0;
    suite_msb      = '0;
    suites_sent    = '0;
    is_server      = 1'b0;
    latched_status = tlshp_pkg::StOk;
    ext_start      = '0;
    ext_size       = '0;
    if (quic) begin
      parse_phase = tlshp_pkg::PhHs;
      bytes_left  = tlshp_pkg::HsHeaderLen;
    end else begin
      parse_phase = tlshp_pkg::PhRec;
    end
  endtask

  task automatic latch_status(input logic [2:0] code);
    latched_status = code;
    parse_phase    = tlshp_pkg::PhError;
  endtask

  // Advance the parser by one byte and queue the beats it causes
  task automatic parse_hello_byte(input logic [7:0] b, input logic fst,
                                  input logic lst, input logic quic);
    tlshp_pkg::result_t made [2];
    int          n;
    logic [15:0] idx;
    logic [15:0] code;
    n       = 0;
    made[0] = '0;
    made[1] = '0;
    if (fst) restart_parse(quic);

    case (parse_phase)
      tlshp_pkg::PhRec: begin
        if (byte_pos == 0 && b != tlshp_pkg::RecTypeHandshake)
          latch_status(tlshp_pkg::StBadRecord);
        else if (byte_pos == 1 && b != tlshp_pkg::VerMajor)
          latch_status(tlshp_pkg::StBadRecord);
        else if (byte_pos == 2 && b > tlshp_pkg::VerMinorMax)
          latch_status(tlshp_pkg::StBadRecord);
        else if (byte_pos >= 4) begin
          parse_phase = tlshp_pkg::PhHs;
          bytes_left  = tlshp_pkg::HsHeaderLen;
        end
      end
      tlshp_pkg::PhHs: begin
        idx = tlshp_pkg::HsHeaderLen - bytes_left;
        if (idx == 0 && b != tlshp_pkg::HsClientHello && b != tlshp_pkg::HsServerHello)
          latch_status(tlshp_pkg::StBadType);
        else if (idx == 4 && b != tlshp_pkg::VerMajor)
          latch_status(tlshp_pkg::StBadVer);
        else if (idx == 5 && (b < 8'd1 || b > tlshp_pkg::VerMinorMax))
          latch_status(tlshp_pkg::StBadVer);
        else begin
          if (idx == 0) is_server = (b == tlshp_pkg::HsServerHello);
          if (bytes_left <= 1) begin
            parse_phase = tlshp_pkg::PhRand;
            bytes_left  = tlshp_pkg::RandomLen;
          end else begin
            bytes_left = bytes_left - 16'd1;
          end
        end
      end
      tlshp_pkg::PhRand: begin
        if (bytes_left <= 1) begin
          bytes_left  = '0;
          parse_phase = tlshp_pkg::PhSidLen;
        end else begin
          bytes_left = bytes_left - 16'd1;
        end
      end
      tlshp_pkg::PhSidLen: begin
        if (b > tlshp_pkg::SessionIdMax) latch_status(tlshp_pkg::StLongSid);
        else begin
          bytes_left  = {8'd0, b};
          parse_phase = (b != 0) ? tlshp_pkg::PhSid : tlshp_pkg::PhCsLenHi;
        end
      end
      tlshp_pkg::PhSid: begin
        if (bytes_left <= 1) begin
          bytes_left  = '0;
          parse_phase = tlshp_pkg::PhCsLenHi;
        end else begin
          bytes_left = bytes_left - 16'd1;
        end
      end
      tlshp_pkg::PhCsLenHi: begin
        len_msb     = b;
        parse_phase = tlshp_pkg::PhCsLenLo;
      end
      tlshp_pkg::PhCsLenLo: begin
        // a server hello carries exactly one suite here, never reported
        if (is_server) parse_phase = tlshp_pkg::PhCompLen;
        else begin
          bytes_left  = {len_msb, b};
          parse_phase = (bytes_left != 0) ? tlshp_pkg::PhCsHi : tlshp_pkg::PhCompLen;
        end
      end
      tlshp_pkg::PhCsHi: begin
        // a lone trailing byte of an odd-length list is skipped
        if (bytes_left <= 1) begin
          bytes_left  = '0;
          parse_phase = tlshp_pkg::PhCompLen;
        end else begin
          suite_msb   = b;
          bytes_left  = bytes_left - 16'd1;
          parse_phase = tlshp_pkg::PhCsLo;
        end
      end
      tlshp_pkg::PhCsLo: begin
        code = {suite_msb, b};
        if (bytes_left > 0) bytes_left = bytes_left - 16'd1;
        if (!reserved_suite_code(code) && suites_sent < MAX_SUITES) begin
          made[n].kind  = tlshp_pkg::KindSuite;
          made[n].suite = code;
          n++;
          suites_sent = suites_sent + 8'd1;
        end
        parse_phase = (bytes_left != 0) ? tlshp_pkg::PhCsHi : tlshp_pkg::PhCompLen;
      end
      tlshp_pkg::PhCompLen: begin
        if (is_server) parse_phase = tlshp_pkg::PhExtHi;
        else begin
          bytes_left  = {8'd0, b};
          parse_phase = (b != 0) ? tlshp_pkg::PhComp : tlshp_pkg::PhExtHi;
        end
      end
      tlshp_pkg::PhComp: begin
        if (bytes_left <= 1) begin
          bytes_left  = '0;
          parse_phase = tlshp_pkg::PhExtHi;
        end else begin
          bytes_left = bytes_left - 16'd1;
        end
      end
      tlshp_pkg::PhExtHi: begin
        len_msb     = b;
        parse_phase = tlshp_pkg::PhExtLo;
      end
      tlshp_pkg::PhExtLo: begin
        if (byte_pos == tlshp_pkg::PosMax) latch_status(tlshp_pkg::StOffsetOvf);
        else begin
          ext_start   = byte_pos + 16'd1;
          ext_size    = {len_msb, b};
          bytes_left  = ext_size;
          parse_phase = (ext_size != 0) ? tlshp_pkg::PhExtBody : tlshp_pkg::PhDone;
        end
      end
      tlshp_pkg::PhExtBody: begin
        if (bytes_left <= 1) begin
          bytes_left  = '0;
          parse_phase = tlshp_pkg::PhDone;
        end else begin
          bytes_left = bytes_left - 16'd1;
        end
      end
      default: ;
    endcase

    // saturate the position at the top of its range
    if (byte_pos != tlshp_pkg::PosMax) byte_pos = byte_pos + 16'd1;

    if (lst) begin
      made[n].kind = tlshp_pkg::KindStatus;
      if (parse_phase == tlshp_pkg::PhDone) begin
        made[n].status     = tlshp_pkg::StOk;
        made[n].srv_hello  = is_server;
        made[n].ext_offset = ext_start;
        made[n].ext_length = ext_size;
      end else if (parse_phase == tlshp_pkg::PhError) begin
        made[n].status = latched_status;
      end else begin
        made[n].status = tlshp_pkg::StTruncated;
      end
      n++;
    end

    for (int k = 0; k < n; k++) begin
      made[k].last_result = (k == n - 1);
      hello_results_due.insert(hello_results_due.size(), made[k]);
    end
  endtask

  // Compare one received beat with the oldest prediction
  task automatic compare_beat(input tlshp_pkg::result_t want,
                              input tlshp_pkg::result_t got,
                              input logic [3:0] pad);
    logic bad;
    bad = 1'b0;
    if (got.kind !== want.kind) begin
      $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
      bad = 1'b1;
    end
    if (got.suite !== want.suite) begin
      $display("%0t: suite expected %04h actual %04h", $time, want.suite, got.suite);
      bad = 1'b1;
    end
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      bad = 1'b1;
    end
    if (got.srv_hello !== want.srv_hello) begin
      $display("%0t: srv_hello expected %0d actual %0d", $time,
               want.srv_hello, got.srv_hello);
      bad = 1'b1;
    end
    if (got.ext_offset !== want.ext_offset) begin
      $display("%0t: ext_offset expected %0d actual %0d", $time,
               want.ext_offset, got.ext_offset);
      bad = 1'b1;
    end
    if (got.ext_length !== want.ext_length) begin
      $display("%0t: ext_length expected %0d actual %0d", $time,
               want.ext_length, got.ext_length);
      bad = 1'b1;
    end
    if (got.last_result !== want.last_result) begin
      $display("%0t: last_result expected %0d actual %0d", $time,
               want.last_result, got.last_result);
      bad = 1'b1;
    end
    if (pad !== 4'd0) begin
      $display("%0t: tdata padding expected 0 actual %0h", $time, pad);
      bad = 1'b1;
    end
    if (bad) mismatches++;
  endtask

  // Predict on accepted input bytes, check accepted output beats
  always @(posedge clk) begin
    if (!rst_n) begin
      restart_parse(1'b0);
      hello_results_due.delete();
    end else begin
      if (in_tvalid && in_tready)
        parse_hello_byte(in_tdata, in_tuser[0], in_tlast, in_tuser[1]);
      if (out_tvalid && out_tready) begin
        seen_beat.kind        = out_tuser;
        seen_beat.suite       = out_tdata[15:0];
        seen_beat.status      = out_tdata[18:16];
        seen_beat.srv_hello   = out_tdata[19];
        seen_beat.ext_offset  = out_tdata[35:20];
        seen_beat.ext_length  = out_tdata[51:36];
        seen_beat.last_result = out_tlast;
        if (hello_results_due.size() == 0) begin
          $display("%0t: unexpected beat expected none actual kind %0d tdata %014h",
                   $time, out_tuser, out_tdata);
          mismatches++;
        end else begin
          due_beat = hello_results_due.pop_front();
          compare_beat(due_beat, seen_beat, out_tdata[55:52]);
        end
      end
    end
    results_due = hello_results_due.size();
  end

endmodule

/* tb/sv/tls_hello_parser_unit_tb.sv */
// Testbench top for the TLS hello parser: builds hello payloads (well-formed,
// corrupted, truncated and noise), drives them with random gaps and gives
// the verdict. Depends on tlshp_pkg, the block and tls_hello_parser_checker.
`timescale 1ns / 1ps

module tls_hello_parser_unit_tb;

  localparam int MAX_SUITES = tlshp_pkg::MaxSuitesDefault;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  int mismatches;
  int results_due;

  // Sender gaps on or off for the payload in flight
  bit tx_idles = 1'b1;

  // Bytes of the payload being built
  logic [7:0] payload[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tls_hello_parser_unit #(.MAX_SUITES(MAX_SUITES)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  tls_hello_parser_checker #(.MAX_SUITES(MAX_SUITES)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .mismatches (mismatches),
    .results_due(results_due)
  );

  // Watchdog
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  // Append one byte to the payload being built
  task automatic add_byte(input logic [7:0] v);
    payload.insert(payload.size(), v);
  endtask

  // Offer one byte, after a random gap, and hold it until accepted
  task automatic send_beat(input logic [7:0] b, input logic fst,
                           input logic lst, input logic quic);
    int gap;
    gap = tx_idles ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= {quic, fst};
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
  endtask

  // Send the built payload; from_quic is random past the first byte
  task automatic send_payload(input bit quic, input bit with_first,
                              input bit with_last);
    for (int i = 0; i < payload.size(); i++)
      send_beat(payload[i], with_first && i == 0,
                with_last && i == payload.size() - 1,
                (i == 0) ? quic : 1'($urandom_range(0, 1)));
  endtask

  // Build a well-formed hello with random content
  task automatic build_hello(input bit quic, input bit server, input int sid_len,
                             input int cs_bytes, input int comp_len,
                             input int ext_len, input int trail);
    logic [7:0]  g;
    logic [15:0] code;
    payload.delete();
    if (!quic) begin
      add_byte(tlshp_pkg::RecTypeHandshake);
      add_byte(tlshp_pkg::VerMajor);
      add_byte(8'($urandom_range(0, 3)));
      add_byte(8'($urandom_range(0, 255)));
      add_byte(8'($urandom_range(0, 255)));
    end
    add_byte(server ? tlshp_pkg::HsServerHello : tlshp_pkg::HsClientHello);
    repeat (3) add_byte(8'($urandom_range(0, 255)));
    add_byte(tlshp_pkg::VerMajor);
    add_byte(8'($urandom_range(1, 3)));
    repeat (32) add_byte(8'($urandom_range(0, 255)));
    add_byte(8'(sid_len));
    repeat (sid_len) add_byte(8'($urandom_range(0, 255)));
    if (server) begin
      // chosen suite, then the compression method
      repeat (3) add_byte(8'($urandom_range(0, 255)));
    end else begin
      add_byte(8'(cs_bytes >> 8));
      add_byte(8'(cs_bytes));
      for (int k = 0; 2 * k < cs_bytes; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          g    = {4'($urandom_range(0, 15)), 4'hA};
          code = {g, g};
        end else begin
          code = 16'($urandom_range(0, 65535));
        end
        add_byte(code[15:8]);
        if (2 * k + 1 < cs_bytes) add_byte(code[7:0]);
      end
      add_byte(8'(comp_len));
      repeat (comp_len) add_byte(8'($urandom_range(0, 255)));
    end
    add_byte(8'(ext_len >> 8));
    add_byte(8'(ext_len));
    repeat (ext_len + trail) add_byte(8'($urandom_range(0, 255)));
  endtask

  // Receiver: random stalls per beat, one long hold-off to back up the block
  initial begin : drain
    int stall;
    int taken;
    bit rx_idles;
    taken    = 0;
    rx_idles = 1'b1;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (taken % 32 == 31) rx_idles = $urandom_range(0, 3) != 0;
      if (taken == 4) stall = 400;
      else stall = rx_idles ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  initial begin : stimulus
    int  random_beats;
    int  pick;
    int  idx;
    int  sid;
    bit  quic;
    bit  srv;
    bit  lst;
    random_beats = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Suite-heavy client hello past the suite capacity, with no first flag
    // after reset, sent back to back so the long receiver hold-off stalls
    // the input
    tx_idles = 1'b0;
    build_hello(1'b0, 1'b0, 32, 241, 1, 10, 0);
    send_payload(1'b0, 1'b0, 1'b1);
    tx_idles = 1'b1;

    // Minimal server hello over QUIC, minimal client hello with trailing bytes
    build_hello(1'b1, 1'b1, 0, 0, 0, 0, 0);
    send_payload(1'b1, 1'b1, 1'b1);
    build_hello(1'b1, 1'b0, 0, 0, 0, 0, 3);
    send_payload(1'b1, 1'b1, 1'b1);

    // Bad record type, major and minor version
    for (int k = 0; k < 3; k++) begin
      build_hello(1'b0, 1'b0, 1, 4, 1, 2, 0);
      payload[k] = (k == 0) ? 8'd23 : (k == 1) ? 8'd2 : 8'd4;
      send_payload(1'b0, 1'b1, 1'b1);
    end

    // Bad handshake type, bad handshake version
    for (int k = 0; k < 5; k++) begin
      build_hello(1'b1, 1'b0, 0, 2, 1, 0, 0);
      case (k)
        0: payload[0] = 8'd0;
        1: payload[0] = 8'd3;
        2: payload[4] = 8'd2;
        3: payload[5] = 8'd0;
        default: payload[5] = 8'd4;
      endcase
      send_payload(1'b1, 1'b1, 1'b1);
    end

    // Session ID too long
    build_hello(1'b1, 1'b1, 33, 0, 0, 0, 0);
    send_payload(1'b1, 1'b1, 1'b1);
    build_hello(1'b0, 1'b0, 0, 2, 0, 0, 0);
    payload[43] = 8'hFF;
    send_payload(1'b0, 1'b1, 1'b1);

    // Truncated, then a payload broken off without last and restarted
    build_hello(1'b0, 1'b0, 8, 12, 2, 6, 0);
    while (payload.size() > 60) payload.delete(payload.size() - 1);
    send_payload(1'b0, 1'b1, 1'b1);
    build_hello(1'b1, 1'b0, 4, 10, 1, 4, 0);
    while (payload.size() > 50) payload.delete(payload.size() - 1);
    send_payload(1'b1, 1'b1, 1'b0);

    // Complete hello, then more bytes without first: status reported again
    build_hello(1'b1, 1'b0, 2, 6, 1, 3, 0);
    send_payload(1'b1, 1'b1, 1'b1);
    repeat (2) begin
      payload.delete();
      repeat (5) add_byte(8'($urandom_range(0, 255)));
      send_payload(1'b0, 1'b0, 1'b1);
    end

    // Random payloads: mostly well-formed, some corrupted, cut short or noise
    while (random_beats < 650) begin
      tx_idles = $urandom_range(0, 3) != 0;
      quic     = 1'($urandom_range(0, 1));
      srv      = $urandom_range(0, 2) == 0;
      sid      = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32) : $urandom_range(0, 4);
      build_hello(quic, srv, sid, $urandom_range(0, 24), $urandom_range(0, 3),
                  $urandom_range(0, 12), ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
      pick = $urandom_range(0, 9);
      lst  = 1'b1;
      case (pick)
        6: begin
          idx = $urandom_range(0, (quic ? 0 : 5) + 38);
          payload[idx] = 8'($urandom_range(0, 255));
        end
        7: begin
          idx = $urandom_range(1, payload.size());
          while (payload.size() > idx) payload.delete(payload.size() - 1);
          lst = 1'($urandom_range(0, 1));
        end
        8: begin
          payload.delete();
          repeat ($urandom_range(1, 20)) add_byte(8'($urandom_range(0, 255)));
        end
        9: begin
          idx = $urandom_range(0, payload.size() - 1);
          payload[idx] = 8'($urandom_range(0, 255));
        end
        default: ;
      endcase
      send_payload(quic, $urandom_range(0, 19) != 0, lst);
      random_beats += payload.size();
    end
    in_tvalid <= 1'b0;

    // Drain remaining beats, then wait for strays
    @(posedge clk);
    wait (results_due == 0);
    repeat (16) @(posedge clk);
    if (mismatches == 0 && results_due == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
